/* hw/rtl/cfr_pkg.sv */
// Shared types and constants for the checksum frame receiver.
package cfr_pkg;

  localparam int MAX_FRAME = 256;
  localparam int LEN_W     = 9;
  localparam int BYTE_W    = 8;

  localparam logic [LEN_W-1:0] MAX_LEN    = LEN_W'(MAX_FRAME);
  localparam logic [LEN_W-1:0] LEN_RESET  = LEN_W'(128);

  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_CMD  = 2'd1;
  localparam logic [1:0] OP_KEY  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_CMD_ABORT = 2'd1;
  localparam logic [1:0] ST_KEY_ABORT = 2'd2;
  localparam logic [1:0] ST_BAD_SUM   = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic [BYTE_W-1:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic              store_valid;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] byte_index;
    logic              frame_done;
    logic [1:0]        status;
  } result_t;

endpackage

/* hw/rtl/checksum_frame_receiver.sv */
// Checksum frame receiver: counts frame_length data bytes with an end-around-carry
// sum, then checks the checksum byte; command or key events abort the frame.
// Every accepted transaction gives exactly one result transaction. The block takes
// one transaction per cycle while the sink does not stall. A result passes through
// the input register, the combinational sum and compare and the result register
// before it is presented to the sink. When the sink stalls, two transactions wait
// and the input is held. frame_length resets to 128; lengths above MAX_FRAME act
// as MAX_FRAME.
module checksum_frame_receiver import cfr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        op,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LEN_W-1:0]  cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              store_valid,
  output logic [BYTE_W-1:0] data_byte,
  output logic [BYTE_W-1:0] byte_index,
  output logic              frame_done,
  output logic [1:0]        status
);

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    advance;
  result_t result;
  result_t out_result;

  assign in_item.op      = op;
  assign in_item.rx_byte = rx_byte;
  assign cfg_ready       = 1'b1;

  cfr_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  cfr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .advance   (advance),
    .item      (item),
    .result    (result)
  );

  cfr_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .result     (result),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result)
  );

  assign store_valid = out_result.store_valid;
  assign data_byte   = out_result.data_byte;
  assign byte_index  = out_result.byte_index;
  assign frame_done  = out_result.frame_done;
  assign status      = out_result.status;

endmodule

/* hw/rtl/cfr_in_stage.sv */
// Input register that holds one accepted transaction until the core takes it.
module cfr_in_stage import cfr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  advance,
  output logic  item_valid,
  output item_t item
);

  logic  valid;
  item_t held;

  assign in_ready   = !valid || advance;
  assign item_valid = valid;
  assign item       = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held <= in_item;
    end
  end

endmodule

/* hw/rtl/cfr_core.sv */
// Frame state, end-around-carry sum and per-byte result logic.
module cfr_core import cfr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [LEN_W-1:0] cfg_data,
  input  logic             advance,
  input  item_t            item,
  output result_t          result
);

  logic [LEN_W-1:0]  frame_length;
  logic [BYTE_W-1:0] running_sum;
  logic [LEN_W-1:0]  bytes_received;

  logic [BYTE_W-1:0] running_sum_next;
  logic [LEN_W-1:0]  bytes_received_next;
  logic [LEN_W-1:0]  eff_len;
  logic [BYTE_W:0]   raw_sum;
  logic [BYTE_W-1:0] wrapped_sum;

  assign eff_len     = (frame_length > MAX_LEN) ? MAX_LEN : frame_length;
  assign raw_sum     = {1'b0, running_sum} + {1'b0, item.rx_byte};
  assign wrapped_sum = raw_sum[BYTE_W-1:0] + BYTE_W'(raw_sum[BYTE_W]);

  always_comb begin
    result              = '0;
    running_sum_next    = running_sum;
    bytes_received_next = bytes_received;
    case (item.op)
      OP_CMD: begin
        result.frame_done   = 1'b1;
        result.status       = ST_CMD_ABORT;
        running_sum_next    = '0;
        bytes_received_next = '0;
      end
      OP_KEY: begin
        result.frame_done   = 1'b1;
        result.status       = ST_KEY_ABORT;
        running_sum_next    = '0;
        bytes_received_next = '0;
      end
      OP_BYTE: begin
        if (bytes_received < eff_len) begin
          result.store_valid  = 1'b1;
          result.data_byte    = item.rx_byte;
          result.byte_index   = bytes_received[BYTE_W-1:0];
          running_sum_next    = wrapped_sum;
          bytes_received_next = bytes_received + LEN_W'(1);
        end else begin
          result.frame_done   = 1'b1;
          result.status       = (item.rx_byte == running_sum) ? ST_OK : ST_BAD_SUM;
          running_sum_next    = '0;
          bytes_received_next = '0;
        end
      end
      default: begin
        result = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= LEN_RESET;
    end else if (cfg_write) begin
      frame_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum    <= '0;
      bytes_received <= '0;
    end else if (advance) begin
      running_sum    <= running_sum_next;
      bytes_received <= bytes_received_next;
    end
  end

endmodule

/* hw/rtl/cfr_out_stage.sv */
// Result register that holds one result transaction until the sink takes it.
module cfr_out_stage import cfr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  result_t result,
  output logic    advance,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_result
);

  logic    valid;
  result_t held;

  assign advance    = item_valid && (!valid || out_ready);
  assign out_valid  = valid;
  assign out_result = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      held <= result;
    end
  end

endmodule

/* test/checksum_frame_receiver_test.sv */
// Testbench for checksum_frame_receiver: directed and random frames, scoreboard check.
`timescale 1ns / 1ps

module checksum_frame_receiver_test;
  import cfr_pkg::*;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam int         CYCLE_MAX  = 400000;
  localparam int         HOLD_CYCLES = 300;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        op = OP_BYTE;
  logic [BYTE_W-1:0] rx_byte = '0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [LEN_W-1:0]  cfg_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              store_valid;
  logic [BYTE_W-1:0] data_byte;
  logic [BYTE_W-1:0] byte_index;
  logic              frame_done;
  logic [1:0]        status;

  checksum_frame_receiver DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .rx_byte(rx_byte),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .store_valid(store_valid), .data_byte(data_byte), .byte_index(byte_index),
    .frame_done(frame_done), .status(status)
  );

  // predictor state
  logic [LEN_W-1:0]  pred_len = LEN_RESET;
  logic [BYTE_W-1:0] pred_sum = '0;
  logic [LEN_W-1:0]  pred_count = '0;
  result_t           expected_results[$];

  int failures = 0;
  int cycles = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_rx = 1'b0;
  logic [LEN_W-1:0] cur_len = LEN_RESET;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [BYTE_W-1:0] add_carry(logic [BYTE_W-1:0] a, logic [BYTE_W-1:0] b);
    logic [BYTE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[BYTE_W-1:0] + {{(BYTE_W-1){1'b0}}, s[BYTE_W]};
  endfunction

  function automatic logic [LEN_W-1:0] eff_len(logic [LEN_W-1:0] l);
    return (l > MAX_LEN) ? MAX_LEN : l;
  endfunction

  function automatic result_t frame_step(logic [1:0] o, logic [BYTE_W-1:0] b);
    result_t r;
    r = '0;
    case (o)
      OP_CMD, OP_KEY: begin
        r.frame_done = 1'b1;
        r.status = (o == OP_CMD) ? ST_CMD_ABORT : ST_KEY_ABORT;
        pred_sum = '0;
        pred_count = '0;
      end
      OP_BYTE: begin
        if (pred_count < eff_len(pred_len)) begin
          r.store_valid = 1'b1;
          r.data_byte = b;
          r.byte_index = pred_count[BYTE_W-1:0];
          pred_sum = add_carry(pred_sum, b);
          pred_count = pred_count + LEN_W'(1);
        end else begin
          r.frame_done = 1'b1;
          r.status = (b == pred_sum) ? ST_OK : ST_BAD_SUM;
          pred_sum = '0;
          pred_count = '0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    cycles++;
    if (cycles > CYCLE_MAX) begin
      $display("checksum_frame_receiver verification failed");
      $finish;
    end else if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no expectation pending");
          failures++;
        end else begin
          want = expected_results.pop_front();
          check_field("store_valid", int'(want.store_valid), int'(store_valid));
          check_field("data_byte", int'(want.data_byte), int'(data_byte));
          check_field("byte_index", int'(want.byte_index), int'(byte_index));
          check_field("frame_done", int'(want.frame_done), int'(frame_done));
          check_field("status", int'(want.status), int'(status));
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(frame_step(op, rx_byte));
      if (cfg_valid && cfg_ready)
        pred_len = cfg_data;
    end
  end

  always @(negedge clk) begin
    out_ready <= !hold_rx && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_item(input logic [1:0] o, input logic [BYTE_W-1:0] b);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (o != OP_UNUSED) items_sent++;
  endtask

  // drop valid, then wait out every pending result and the pipeline
  task automatic wait_drained;
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] len);
    cfg_valid <= 1'b1;
    cfg_data <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_len = len;
  endtask

  task automatic send_frame(input int n_data, input bit good);
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] b;
    sum = '0;
    for (int i = 0; i < n_data; i++) begin
      if ($urandom_range(99) < 3)
        send_item(OP_UNUSED, BYTE_W'($urandom_range(255)));
      if ($urandom_range(99) < 2) begin
        send_item($urandom_range(1) ? OP_CMD : OP_KEY, BYTE_W'($urandom_range(255)));
        return;
      end
      b = BYTE_W'($urandom_range(255));
      send_item(OP_BYTE, b);
      sum = add_carry(sum, b);
    end
    if (!good) sum = sum ^ (8'h01 << $urandom_range(7));
    send_item(OP_BYTE, sum);
  endtask

  task automatic test_directed;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_item(OP_UNUSED, 8'hFF);
    send_item(OP_CMD, 8'h00);
    send_item(OP_KEY, 8'hFF);
    wait_drained;
    write_length(9'd0);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    wait_drained;
    write_length(9'd2);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, 8'h80);
    send_item(OP_BYTE, 8'h80);
    send_item(OP_BYTE, 8'h01);
    send_item(OP_BYTE, 8'h01);
    send_item(OP_BYTE, 8'h02);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'h10);
    send_item(OP_CMD, 8'h55);
    send_item(OP_BYTE, 8'h20);
    send_item(OP_KEY, 8'hAA);
    send_item(OP_BYTE, 8'h05);
    send_item(OP_UNUSED, 8'hAA);
    send_item(OP_BYTE, 8'h06);
    send_item(OP_BYTE, 8'h0B);
    wait_drained;
    // leave a frame open, then shorten the length below its byte count
    write_length(9'd4);
    send_item(OP_BYTE, 8'h11);
    send_item(OP_BYTE, 8'h22);
    send_item(OP_BYTE, 8'h33);
    wait_drained;
    write_length(9'd2);
    send_item(OP_BYTE, 8'h66);
    wait_drained;
  endtask

  task automatic test_length_extremes;
    write_length(9'd0);
    send_frame(0, 1'b1);
    wait_drained;
    write_length(9'd1);
    send_frame(1, 1'b1);
    wait_drained;
    write_length(9'd256);
    send_frame(256, 1'b1);
    wait_drained;
    write_length(9'd511);
    send_frame(256, 1'b0);
    wait_drained;
  endtask

  task automatic run_traffic(input int idle_pct, input int stall_pct, input int n);
    int target;
    int frames_left;
    int pick;
    int n_data;
    int len;
    target = items_sent + n;
    frames_left = 0;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    while (items_sent < target) begin
      if (frames_left == 0) begin
        wait_drained;
        pick = $urandom_range(99);
        frames_left = $urandom_range(3, 10);
        if (pick < 80) write_length(LEN_W'($urandom_range(12)));
        else if (pick < 94) write_length(LEN_W'($urandom_range(13, 40)));
        else begin
          frames_left = 1;
          if (pick < 96) write_length(9'd256);
          else if (pick < 97) write_length(9'd255);
          else if (pick < 98) write_length(9'd511);
          else write_length(LEN_W'($urandom_range(257, 510)));
        end
      end
      len = int'(eff_len(cur_len));
      n_data = ($urandom_range(99) < 10) ? $urandom_range(len + 2) : len;
      send_frame(n_data, $urandom_range(99) < 80);
      frames_left--;
    end
    wait_drained;
  endtask

  task automatic test_random_traffic;
    run_traffic(0, 0, 320);
    run_traffic(60, 0, 320);
    run_traffic(0, 60, 320);
    run_traffic(37, 37, 320);
  endtask

  task automatic test_backpressure;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_length(9'd5);
    fork
      begin
        @(posedge clk);
        hold_rx = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
      end
    join_none
    repeat (7) send_frame(5, 1'($urandom_range(1)));
    wait_drained;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed;
    test_length_extremes;
    test_random_traffic;
    test_backpressure;
    wait_drained;
    if (failures == 0) begin
      $display("checksum_frame_receiver verification clean");
    end else begin
      $display("checksum_frame_receiver verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/cfr_pkg.sv
hw/rtl/cfr_in_stage.sv
hw/rtl/cfr_core.sv
hw/rtl/cfr_out_stage.sv
hw/rtl/checksum_frame_receiver.sv
test/checksum_frame_receiver_test.sv
